>>> hw/rtl/sfla_pkg.sv
// Shared types and constants for the slot free-list allocator.
package sfla_pkg;

  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 7;
  localparam int INUSE_W   = 11;
  localparam int LEN_W     = 32;

  localparam int CAPACITY_DEF  = 1024;
  localparam int MAX_BATCH_DEF = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_LINK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot_index;
    logic               granted;
    logic               last;
    logic [INUSE_W-1:0] in_use;
  } result_t;

endpackage

>>> hw/rtl/sfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sfla_ctrl.sv
// Sequencer for the allocator: free-list push/pop, virgin countdown, per-slot results.
module sfla_ctrl #(
  parameter int CAPACITY  = sfla_pkg::CAPACITY_DEF,
  parameter int MAX_BATCH = sfla_pkg::MAX_BATCH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [sfla_pkg::COUNT_W-1:0] in_count,
  input  logic [sfla_pkg::SLOT_W-1:0]  in_slot,
  output sfla_pkg::result_t            res,
  input  logic                         res_take
);

  localparam int SLOT_W    = sfla_pkg::SLOT_W;
  localparam int COUNT_W   = sfla_pkg::COUNT_W;
  localparam int INUSE_W   = sfla_pkg::INUSE_W;
  localparam int LEN_W     = sfla_pkg::LEN_W;
  localparam int VW        = $clog2(CAPACITY + 1);
  localparam int MEM_DEPTH = (CAPACITY < (1 << SLOT_W)) ? CAPACITY : (1 << SLOT_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [COUNT_W-1:0] BATCH = COUNT_W'(MAX_BATCH);

  sfla_pkg::state_t    state_r, state_nxt;
  logic [SLOT_W-1:0]   top_r, top_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [VW-1:0]       virgin_r, virgin_nxt;
  logic [INUSE_W-1:0]  in_use_r, in_use_nxt;
  logic [COUNT_W-1:0]  want_r, want_nxt;
  logic [COUNT_W-1:0]  n_r, n_nxt;
  logic [SLOT_W-1:0]   got_r, got_nxt;
  logic                grant_r, grant_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [SLOT_W-1:0]   rdata;
  logic                empty;
  logic                slot_ok;

  sfla_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MEM_DEPTH)
  ) u_link (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign empty   = (len_r == '0) && (virgin_r == '0);
  assign slot_ok = (32'(in_slot) < CAPACITY);
  assign waddr   = in_slot[AW-1:0];
  assign raddr   = top_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sfla_pkg::ST_IDLE;
      top_r    <= '0;
      len_r    <= '0;
      virgin_r <= VW'(CAPACITY);
      in_use_r <= '0;
      want_r   <= '0;
      n_r      <= '0;
      grant_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      len_r    <= len_nxt;
      virgin_r <= virgin_nxt;
      in_use_r <= in_use_nxt;
      want_r   <= want_nxt;
      n_r      <= n_nxt;
      grant_r  <= grant_nxt;
    end
  end

  always_ff @(posedge clk) begin
    got_r <= got_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    top_nxt    = top_r;
    len_nxt    = len_r;
    virgin_nxt = virgin_r;
    in_use_nxt = in_use_r;
    want_nxt   = want_r;
    n_nxt      = n_r;
    got_nxt    = got_r;
    grant_nxt  = grant_r;
    we         = 1'b0;
    in_stall   = (state_r != sfla_pkg::ST_IDLE);
    res        = '0;

    unique case (state_r)
      sfla_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == sfla_pkg::OP_FREE) begin
            // push onto the free list; out-of-range slots drop silently
            if (slot_ok) begin
              we         = 1'b1;
              top_nxt    = in_slot;
              in_use_nxt = in_use_r - INUSE_W'(1);
              if (len_r != '1) begin
                len_nxt = len_r + LEN_W'(1);
              end
            end
          end else begin
            if (in_count == '0) begin
              want_nxt = COUNT_W'(1);
            end else if (in_count > BATCH) begin
              want_nxt = BATCH;
            end else begin
              want_nxt = in_count;
            end
            n_nxt     = '0;
            state_nxt = sfla_pkg::ST_PICK;
          end
        end
      end

      sfla_pkg::ST_PICK: begin
        if (empty) begin
          grant_nxt = 1'b0;
          got_nxt   = '0;
          state_nxt = sfla_pkg::ST_SEND;
        end else if (len_r != '0) begin
          // link read issued at the head; next head arrives next cycle
          grant_nxt = 1'b1;
          got_nxt   = top_r;
          state_nxt = sfla_pkg::ST_LINK;
        end else begin
          grant_nxt  = 1'b1;
          virgin_nxt = virgin_r - VW'(1);
          got_nxt    = SLOT_W'(virgin_r - VW'(1));
          state_nxt  = sfla_pkg::ST_SEND;
        end
      end

      sfla_pkg::ST_LINK: begin
        top_nxt   = rdata;
        len_nxt   = len_r - LEN_W'(1);
        state_nxt = sfla_pkg::ST_SEND;
      end

      sfla_pkg::ST_SEND: begin
        res.valid      = 1'b1;
        res.slot_index = got_r;
        res.granted    = grant_r;
        res.last       = !grant_r || ((n_r + COUNT_W'(1)) == want_r) || empty;
        res.in_use     = in_use_r + INUSE_W'(grant_r);
        if (res_take) begin
          in_use_nxt = res.in_use;
          n_nxt      = n_r + COUNT_W'(1);
          state_nxt  = res.last ? sfla_pkg::ST_IDLE : sfla_pkg::ST_PICK;
        end
      end

      default: begin
        state_nxt = sfla_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfla_pkg::ST_IDLE && in_valid && in_op == sfla_pkg::OP_FREE && slot_ok
     && len_r != '1) |=> (len_r == $past(len_r) + LEN_W'(1) && top_r == $past(in_slot)))
    else $error("free request did not push the slot");

  a_link_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfla_pkg::ST_LINK) |-> ($past(state_r) == sfla_pkg::ST_PICK && len_r != '0))
    else $error("link load without a pending pop");

  a_virgin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(virgin_r) <= CAPACITY))
    else $error("virgin count above capacity");

  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sfla_pkg::ST_IDLE) |-> (n_r < want_r && want_r <= BATCH && want_r != '0))
    else $error("grant count ran past the request");
`endif

endmodule

>>> hw/rtl/slot_free_list_allocator_top.sv
// Top level of the slot free-list allocator: sequencer plus output register.
//
// Input channel (in_valid/in_stall, in_op/in_count/in_slot): a free request
// (in_op = 1) pushes in_slot onto a LIFO free list and returns
// nothing; a slot at or above CAPACITY is dropped. An allocate request
// (in_op = 0) asks for in_count slots (0 counts as 1, above MAX_BATCH is
// clipped) and yields one result per granted slot, the last one marked by
// out_last; with nothing free it yields a single result with out_granted = 0.
// The free list is served first, then never-used slots from the top down.
// Timing: in_stall is high for the whole of an allocate request. Each slot
// from the free list passes through head pick, link RAM read and send;
// each never-used slot through pick and send only, as the link RAM's
// registered read sets the extra step.
// Output (out_valid/out_stall): a registered stage; while out_stall is high
// the result holds and the sequencer waits in its send step.
// Reset (rst_n low, synchronous) empties the free list, restores all
// CAPACITY slots as never used and clears in_use. Link RAM is not cleared.
module slot_free_list_allocator_top #(
  parameter int CAPACITY  = sfla_pkg::CAPACITY_DEF,
  parameter int MAX_BATCH = sfla_pkg::MAX_BATCH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [sfla_pkg::COUNT_W-1:0] in_count,
  input  logic [sfla_pkg::SLOT_W-1:0]  in_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfla_pkg::SLOT_W-1:0]  out_slot_index,
  output logic                         out_granted,
  output logic                         out_last,
  output logic [sfla_pkg::INUSE_W-1:0] out_in_use
);

  sfla_pkg::result_t res;
  logic              res_take;
  logic              out_valid_r;
  sfla_pkg::result_t out_r;

  assign res_take = !out_valid_r || !out_stall;

  sfla_ctrl #(
    .CAPACITY  (CAPACITY),
    .MAX_BATCH (MAX_BATCH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_count (in_count),
    .in_slot  (in_slot),
    .res      (res),
    .res_take (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_r.slot_index;
  assign out_granted    = out_r.granted;
  assign out_last       = out_r.last;
  assign out_in_use     = out_r.in_use;

`ifndef SYNTHESIS
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slot_index) && $stable(out_last)))
    else $error("stalled result changed");

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("request accepted before the batch finished");

  a_no_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_last && out_slot_index == '0))
    else $error("exhausted result must be last with zero slot");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the slot free-list allocator: directed table, then random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_W      = sfla_pkg::SLOT_W;
  localparam int COUNT_W     = sfla_pkg::COUNT_W;
  localparam int INUSE_W     = sfla_pkg::INUSE_W;
  localparam int POOL_SLOTS  = sfla_pkg::CAPACITY_DEF;
  localparam int BATCH_MAX   = sfla_pkg::MAX_BATCH_DEF;
  localparam int RAND_ITEMS  = 124;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic               granted;
    logic               last;
    logic [INUSE_W-1:0] in_use;
  } grant_t;

  typedef struct {
    logic               op;
    logic [COUNT_W-1:0] cnt;
    logic [SLOT_W-1:0]  slt;
    bit                 typed;
    grant_t             want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = sfla_pkg::OP_ALLOC;
  logic [COUNT_W-1:0] in_count = 7'd1;
  logic [SLOT_W-1:0]  in_slot = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SLOT_W-1:0]  out_slot_index;
  logic               out_granted;
  logic               out_last;
  logic [INUSE_W-1:0] out_in_use;

  slot_free_list_allocator_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_count       (in_count),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_granted    (out_granted),
    .out_last       (out_last),
    .out_in_use     (out_in_use)
  );

  always #2 clk = ~clk;

  // Allocator shadow state
  logic [SLOT_W-1:0] link_mem [POOL_SLOTS];
  logic [SLOT_W-1:0] list_head = '0;
  logic [31:0]       list_len = '0;
  int                fresh_left = POOL_SLOTS;
  logic [31:0]       grants_total = '0;
  logic [31:0]       frees_total = '0;

  grant_t            step_grants[$];
  grant_t            pending_grants[$];
  logic [SLOT_W-1:0] held_slots[$];
  stim_row_t         script[$];

  int mismatches = 0;
  int sent = 0;
  int total_items = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  task automatic predict_grants(input logic op, input logic [COUNT_W-1:0] cnt,
                                input logic [SLOT_W-1:0] slt);
    int                want;
    int                n;
    logic [SLOT_W-1:0] got;
    logic [31:0]       diff;
    grant_t            g;
    step_grants.delete();
    // slot is 10 bits wide and the pool holds 1024, so every free is in range
    if (op == sfla_pkg::OP_FREE) begin
      link_mem[slt] = list_head;
      list_head = slt;
      if (list_len != '1) list_len++;
      frees_total++;
      return;
    end
    want = (cnt == 0) ? 1 : ((cnt > BATCH_MAX) ? BATCH_MAX : int'(cnt));
    if (list_len == 0 && fresh_left == 0) begin
      diff = grants_total - frees_total;
      g = '{slot_index: '0, granted: 1'b0, last: 1'b1, in_use: diff[INUSE_W-1:0]};
      step_grants.push_back(g);
      return;
    end
    n = 0;
    while (n < want && (list_len != 0 || fresh_left != 0)) begin
      // drain the free list before touching never-used slots
      if (list_len != 0) begin
        got = list_head;
        list_head = link_mem[got];
        list_len--;
      end else begin
        fresh_left--;
        got = fresh_left[SLOT_W-1:0];
      end
      grants_total++;
      diff = grants_total - frees_total;
      g.slot_index = got;
      g.granted = 1'b1;
      g.last = (n + 1 == want) || (list_len == 0 && fresh_left == 0);
      g.in_use = diff[INUSE_W-1:0];
      step_grants.push_back(g);
      n++;
    end
  endtask

  task automatic add_row(input logic op, input int cnt, input int slt, input bit typed,
                         input grant_t want);
    stim_row_t r;
    r.op = op;
    r.cnt = cnt[COUNT_W-1:0];
    r.slt = slt[SLOT_W-1:0];
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  task automatic send_request(input logic op, input logic [COUNT_W-1:0] cnt,
                              input logic [SLOT_W-1:0] slt, input bit typed,
                              input grant_t want);
    int mode;
    int k;
    mode = (sent * 3) / total_items;
    case (mode)
      0:       begin send_idle_pct = 20; recv_stall_pct = 61; end
      1:       begin send_idle_pct = 61; recv_stall_pct = 20; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_count <= cnt;
    in_slot  <= slt;
    do @(posedge clk); while (in_stall);
    predict_grants(op, cnt, slt);
    // keep the list of outstanding slots in step so later frees are well formed
    if (op == sfla_pkg::OP_FREE) begin
      k = -1;
      foreach (held_slots[i]) if (k < 0 && held_slots[i] == slt) k = i;
      if (k >= 0) held_slots.delete(k);
    end
    foreach (step_grants[i]) begin
      if (step_grants[i].granted) held_slots.push_back(step_grants[i].slot_index);
      if (!typed) pending_grants.push_back(step_grants[i]);
    end
    if (typed) pending_grants.push_back(want);
    sent++;
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    grant_t got;
    grant_t exp;
    if (rst_n && out_valid && !out_stall) begin
      got = '{slot_index: out_slot_index, granted: out_granted, last: out_last,
              in_use: out_in_use};
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slot %0d granted %0b last %0b in_use %0d",
                   got.slot_index, got.granted, got.last, got.in_use);
      end else begin
        exp = pending_grants.pop_front();
        if (got.slot_index != exp.slot_index || got.granted != exp.granted ||
            got.last != exp.last || got.in_use != exp.in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp slot %0d g %0b l %0b use %0d, got slot %0d g %0b l %0b use %0d",
                     exp.slot_index, exp.granted, exp.last, exp.in_use,
                     got.slot_index, got.granted, got.last, got.in_use);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: cycles without any handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 pick;
    int                 sel;
    logic               op;
    logic [COUNT_W-1:0] cnt;
    logic [SLOT_W-1:0]  slt;

    // first grant after reset comes from the top of the pool
    add_row(sfla_pkg::OP_ALLOC, 1, 0, 1'b1, '{slot_index: 10'd1023, granted: 1'b1,
                                             last: 1'b1, in_use: 11'd1});
    // zero count asks for one slot
    add_row(sfla_pkg::OP_ALLOC, 0, 0, 1'b1, '{slot_index: 10'd1022, granted: 1'b1,
                                             last: 1'b1, in_use: 11'd2});
    add_row(sfla_pkg::OP_FREE, 1, 1023, 1'b0, '0);
    // oversized count is clipped; freed slot first, then never-used ones
    add_row(sfla_pkg::OP_ALLOC, 127, 0, 1'b0, '0);
    // drain the rest; the final batch runs dry before its count
    for (int i = 0; i < 15; i++) add_row(sfla_pkg::OP_ALLOC, 64, 0, 1'b0, '0);
    add_row(sfla_pkg::OP_ALLOC, 1, 1023, 1'b1, '{slot_index: '0, granted: 1'b0, last: 1'b1,
                                                in_use: 11'd1024});
    add_row(sfla_pkg::OP_FREE, 127, 1023, 1'b0, '0);
    add_row(sfla_pkg::OP_FREE, 0, 0, 1'b0, '0);
    add_row(sfla_pkg::OP_ALLOC, 64, 0, 1'b0, '0);
    // double free of one slot: the list hands it out twice
    add_row(sfla_pkg::OP_FREE, 1, 5, 1'b0, '0);
    add_row(sfla_pkg::OP_FREE, 1, 5, 1'b0, '0);
    add_row(sfla_pkg::OP_ALLOC, 3, 0, 1'b0, '0);
    total_items = script.size() + RAND_ITEMS;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_request(script[i].op, script[i].cnt, script[i].slt, script[i].typed, script[i].want);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 55 && held_slots.size() != 0) begin
        op  = sfla_pkg::OP_FREE;
        slt = held_slots[$urandom_range(held_slots.size() - 1)];
        cnt = COUNT_W'($urandom);
      end else if (pick < 92) begin
        op  = sfla_pkg::OP_ALLOC;
        slt = SLOT_W'($urandom);
        sel = $urandom_range(19);
        if (sel == 0)     cnt = '0;
        else if (sel == 1) cnt = COUNT_W'($urandom_range(127, 65));
        else if (sel < 5)  cnt = COUNT_W'($urandom_range(64, 1));
        else               cnt = COUNT_W'($urandom_range(8, 1));
      end else begin
        // stray free of any slot, possibly one already on the list
        op  = sfla_pkg::OP_FREE;
        slt = SLOT_W'($urandom);
        cnt = COUNT_W'($urandom);
      end
      send_request(op, cnt, slt, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
